FILE: hdl/unaligned_load_store_fixup_core_macros.svh
// Assertion macros for the unaligned load/store fixup core.
`ifndef UNALIGNED_LOAD_STORE_FIXUP_CORE_MACROS_SVH
`define UNALIGNED_LOAD_STORE_FIXUP_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ULSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ulsf same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ULSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ulsf next-cycle check failed");

`endif

FILE: hdl/ulsf_pkg.sv
// Package for the unaligned load/store fixup core: codes, decode and byte swaps.
package ulsf_pkg;

    typedef enum logic [1:0] {
        ST_FIXED   = 2'd0,
        ST_FETCH   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_DATA    = 2'd3
    } status_t;

    typedef struct packed {
        logic valid;
        logic load;
        logic half;
        logic alg;
        logic rev;
        logic upd;
    } form_t;

    // Primary opcodes
    localparam logic [5:0] OP_X     = 6'd31;
    localparam logic [5:0] OP_LWZ   = 6'd32;
    localparam logic [5:0] OP_LWZU  = 6'd33;
    localparam logic [5:0] OP_STW   = 6'd36;
    localparam logic [5:0] OP_STWU  = 6'd37;
    localparam logic [5:0] OP_LHZ   = 6'd40;
    localparam logic [5:0] OP_LHZU  = 6'd41;
    localparam logic [5:0] OP_LHA   = 6'd42;
    localparam logic [5:0] OP_LHAU  = 6'd43;
    localparam logic [5:0] OP_STH   = 6'd44;
    localparam logic [5:0] OP_STHU  = 6'd45;

    // Extended opcodes under primary opcode 31
    localparam logic [9:0] XO_LWZX   = 10'd23;
    localparam logic [9:0] XO_LWZUX  = 10'd55;
    localparam logic [9:0] XO_STWX   = 10'd151;
    localparam logic [9:0] XO_STWUX  = 10'd183;
    localparam logic [9:0] XO_LHZX   = 10'd279;
    localparam logic [9:0] XO_LHZUX  = 10'd311;
    localparam logic [9:0] XO_LHAX   = 10'd343;
    localparam logic [9:0] XO_LHAUX  = 10'd375;
    localparam logic [9:0] XO_STHX   = 10'd407;
    localparam logic [9:0] XO_STHUX  = 10'd439;
    localparam logic [9:0] XO_LWBRX  = 10'd534;
    localparam logic [9:0] XO_STWBRX = 10'd662;
    localparam logic [9:0] XO_LHBRX  = 10'd790;
    localparam logic [9:0] XO_STHBRX = 10'd918;

    localparam logic [31:0] HALF_SIGN_FILL = 32'hffff_0000;
    localparam logic [31:0] PC_STEP        = 32'd4;

    // Fields: valid, load, half, alg, rev, upd
    localparam form_t F_NONE = 6'b000000;

    function automatic form_t decode_form(input logic [5:0] op, input logic [9:0] xo);
        form_t f;
        f = F_NONE;
        unique case (op)
            OP_LWZ:  f = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            OP_LWZU: f = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
            OP_STW:  f = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
            OP_STWU: f = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
            OP_LHZ:  f = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
            OP_LHZU: f = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
            OP_LHA:  f = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
            OP_LHAU: f = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
            OP_STH:  f = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
            OP_STHU: f = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
            OP_X:
            begin
                unique case (xo)
                    XO_LWZX:   f = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
                    XO_LWZUX:  f = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
                    XO_STWX:   f = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
                    XO_STWUX:  f = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
                    XO_LHZX:   f = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
                    XO_LHZUX:  f = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
                    XO_LHAX:   f = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
                    XO_LHAUX:  f = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
                    XO_STHX:   f = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
                    XO_STHUX:  f = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
                    XO_LWBRX:  f = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
                    XO_STWBRX: f = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
                    XO_LHBRX:  f = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
                    XO_STHBRX: f = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
                    default:   f = F_NONE;
                endcase
            end
            default: f = F_NONE;
        endcase
        return f;
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

FILE: hdl/unaligned_load_store_fixup_core.sv
// Unaligned integer load/store fixup core: decode, extend, swap and writeback select.
//
// Takes one trapped PowerPC integer word or halfword access per item (the instruction
// word, its pc, the fault address, the rs/rt register value, the bytes read and the
// two fault flags) and returns one result item: a status, the store data, the target
// and base register writebacks and the next pc. The block accepts one item every
// clock cycle unless in_stall is high; each item is first held in the input register,
// then decode and data shaping write it into the result register. The result
// register holds while the output is stalled; the input register still takes one
// more item if it is empty and then holds it until the waiting result is read.
// lmw, stmw and every unlisted opcode report
// unknown. A fetch fault beats everything and reports the pc; an access fault on a
// decoded form reports a data fault with no writes. An update form whose RA is zero,
// or for a load equals RT, keeps its load or store but drops the RA write and raises
// invalid_form. No kept state beyond the two pipeline registers; reset only empties
// them.
`include "unaligned_load_store_fixup_core_macros.svh"

module unaligned_load_store_fixup_core (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instr_word,
    input  logic [31:0] pc,
    input  logic [31:0] fault_address,
    input  logic [31:0] source_value,
    input  logic [31:0] mem_data,
    input  logic        fetch_fault,
    input  logic        access_fault,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] report_address,
    output logic [31:0] next_pc,
    output logic        store_enable,
    output logic        store_is_half,
    output logic [31:0] store_data,
    output logic        target_write,
    output logic [4:0]  target_index,
    output logic [31:0] target_value,
    output logic        base_write,
    output logic [4:0]  base_index,
    output logic        invalid_form
);
    import ulsf_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [31:0] instr_reg;
    logic [31:0] pc_reg;
    logic [31:0] addr_reg;
    logic [31:0] src_reg;
    logic [31:0] mem_reg;
    logic        ffault_reg;
    logic        afault_reg;

    // Result register
    logic        out_valid_reg;
    status_t     status_reg,        status_next;
    logic [31:0] report_reg,        report_next;
    logic [31:0] npc_reg,           npc_next;
    logic        st_en_reg,         st_en_next;
    logic        st_half_reg,       st_half_next;
    logic [31:0] st_data_reg,       st_data_next;
    logic        t_wr_reg,          t_wr_next;
    logic [4:0]  t_idx_reg,         t_idx_next;
    logic [31:0] t_val_reg,         t_val_next;
    logic        b_wr_reg,          b_wr_next;
    logic [4:0]  b_idx_reg,         b_idx_next;
    logic        inval_reg,         inval_next;

    // Pipeline flow: the result register moves when empty or drained; the input
    // register moves when empty or when its item moves on.
    logic        adv_out;
    logic        adv_in;
    logic        accept;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign in_stall = !adv_in;
    assign accept   = in_valid && adv_in;

    // Instruction fields
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  ra;
    logic [9:0]  xo;
    form_t       form;
    logic [15:0] mem_half;
    logic [15:0] src_half;

    assign op       = instr_reg[31:26];
    assign rs       = instr_reg[25:21];
    assign ra       = instr_reg[20:16];
    assign xo       = instr_reg[10:1];
    assign form     = decode_form(op, xo);
    assign mem_half = mem_reg[15:0];
    assign src_half = src_reg[15:0];

    always_comb
    begin
        status_next  = ST_FIXED;
        report_next  = addr_reg;
        npc_next     = pc_reg;
        st_en_next   = 1'b0;
        st_half_next = 1'b0;
        st_data_next = '0;
        t_wr_next    = 1'b0;
        t_idx_next   = rs;
        t_val_next   = '0;
        b_wr_next    = 1'b0;
        b_idx_next   = ra;
        inval_next   = 1'b0;

        if (ffault_reg)
        begin
            // Fetch fault wins: report the pc, clear the register numbers.
            status_next = ST_FETCH;
            report_next = pc_reg;
            t_idx_next  = '0;
            b_idx_next  = '0;
        end
        else if (!form.valid)
        begin
            status_next = ST_UNKNOWN;
        end
        else if (afault_reg)
        begin
            status_next = ST_DATA;
        end
        else
        begin
            status_next = ST_FIXED;
            npc_next    = pc_reg + PC_STEP;
            if (form.load)
            begin
                t_wr_next = 1'b1;
                if (form.half)
                begin
                    // Byte reversed halfword loads are never sign extended.
                    if (form.rev)
                        t_val_next = {16'h0000, swap16(mem_half)};
                    else if (form.alg && mem_half[15])
                        t_val_next = HALF_SIGN_FILL | {16'h0000, mem_half};
                    else
                        t_val_next = {16'h0000, mem_half};
                end
                else
                begin
                    t_val_next = form.rev ? swap32(mem_reg) : mem_reg;
                end
            end
            else
            begin
                st_en_next   = 1'b1;
                st_half_next = form.half;
                if (form.half)
                    st_data_next = {16'h0000, form.rev ? swap16(src_half) : src_half};
                else
                    st_data_next = form.rev ? swap32(src_reg) : src_reg;
            end
            if (form.upd)
            begin
                if (ra == '0 || (form.load && ra == rs))
                    inval_next = 1'b1;
                else
                    b_wr_next = 1'b1;
            end
        end
    end

    // Control: valid flags of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
                in_valid_reg <= in_valid;
            if (adv_out)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload: capture on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg  <= instr_word;
            pc_reg     <= pc;
            addr_reg   <= fault_address;
            src_reg    <= source_value;
            mem_reg    <= mem_data;
            ffault_reg <= fetch_fault;
            afault_reg <= access_fault;
        end
        if (adv_out && in_valid_reg)
        begin
            status_reg  <= status_next;
            report_reg  <= report_next;
            npc_reg     <= npc_next;
            st_en_reg   <= st_en_next;
            st_half_reg <= st_half_next;
            st_data_reg <= st_data_next;
            t_wr_reg    <= t_wr_next;
            t_idx_reg   <= t_idx_next;
            t_val_reg   <= t_val_next;
            b_wr_reg    <= b_wr_next;
            b_idx_reg   <= b_idx_next;
            inval_reg   <= inval_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign report_address = report_reg;
    assign next_pc        = npc_reg;
    assign store_enable   = st_en_reg;
    assign store_is_half  = st_half_reg;
    assign store_data     = st_data_reg;
    assign target_write   = t_wr_reg;
    assign target_index   = t_idx_reg;
    assign target_value   = t_val_reg;
    assign base_write     = b_wr_reg;
    assign base_index     = b_idx_reg;
    assign invalid_form   = inval_reg;

    // Terms for the checks below
    logic fwd_item;
    logic err_out;
    logic any_write;

    assign fwd_item  = in_valid_reg && adv_out;
    assign err_out   = out_valid_reg && status_reg != ST_FIXED;
    assign any_write = st_en_reg || t_wr_reg || b_wr_reg || inval_reg;

    // An item in the input register reaches the output once the output can move.
    `ULSF_ASSERT_NEXT(a_item_advances, clk, rst_n, fwd_item, out_valid_reg)
    // A fetch fault item always comes out as a fetch fault.
    `ULSF_ASSERT_NEXT(a_fetch_wins, clk, rst_n, fwd_item && ffault_reg, status_reg == ST_FETCH)
    // A result is never both a load and a store.
    `ULSF_ASSERT_NOW(a_load_xor_store, clk, rst_n, out_valid_reg, !(st_en_reg && t_wr_reg))
    // A suppressed base write and a base write never come together.
    `ULSF_ASSERT_NOW(a_base_or_invalid, clk, rst_n, out_valid_reg, !(b_wr_reg && inval_reg))
    // Anything but a fixed status carries no writes.
    `ULSF_ASSERT_NOW(a_no_write_on_error, clk, rst_n, err_out, !any_write)

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the unaligned load/store fixup core.
module testbench;

    import ulsf_pkg::*;

    // Opcodes the core must refuse; they are not part of the package.
    localparam logic [5:0] OP_LMW  = 6'd46;
    localparam logic [5:0] OP_STMW = 6'd47;

    localparam int NUM_FORMS    = 24;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // One trapped access as it enters the core.
    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] pc;
        logic [31:0] fault_address;
        logic [31:0] source_value;
        logic [31:0] mem_data;
        logic        fetch_fault;
        logic        access_fault;
    } trap_t;

    // One fixup result as it leaves the core.
    typedef struct packed {
        status_t     status;
        logic [31:0] report_address;
        logic [31:0] next_pc;
        logic        store_enable;
        logic        store_is_half;
        logic [31:0] store_data;
        logic        target_write;
        logic [4:0]  target_index;
        logic [31:0] target_value;
        logic        base_write;
        logic [4:0]  base_index;
        logic        invalid_form;
    } fixup_t;

    // Access kind behind one opcode.
    typedef struct packed {
        logic known;
        logic is_load;
        logic is_half;
        logic is_alg;
        logic is_rev;
        logic is_upd;
    } access_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instr_word;
    logic [31:0] pc;
    logic [31:0] fault_address;
    logic [31:0] source_value;
    logic [31:0] mem_data;
    logic        fetch_fault;
    logic        access_fault;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] report_address;
    logic [31:0] next_pc;
    logic        store_enable;
    logic        store_is_half;
    logic [31:0] store_data;
    logic        target_write;
    logic [4:0]  target_index;
    logic [31:0] target_value;
    logic        base_write;
    logic [4:0]  base_index;
    logic        invalid_form;

    fixup_t fixups_pending[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     gaps_enabled = 1'b1;

    unaligned_load_store_fixup_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .instr_word     (instr_word),
        .pc             (pc),
        .fault_address  (fault_address),
        .source_value   (source_value),
        .mem_data       (mem_data),
        .fetch_fault    (fetch_fault),
        .access_fault   (access_fault),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .report_address (report_address),
        .next_pc        (next_pc),
        .store_enable   (store_enable),
        .store_is_half  (store_is_half),
        .store_data     (store_data),
        .target_write   (target_write),
        .target_index   (target_index),
        .target_value   (target_value),
        .base_write     (base_write),
        .base_index     (base_index),
        .invalid_form   (invalid_form)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Classify an opcode pair; anything not listed stays unknown.
    function automatic access_kind_t classify_access(input logic [5:0] op,
                                                     input logic [9:0] xo);
        access_kind_t k;
        k = '0;
        k.known = 1'b1;
        if (op == OP_X)
        begin
            case (xo)
                XO_LWZX:   k.is_load = 1'b1;
                XO_LWZUX:  {k.is_load, k.is_upd} = 2'b11;
                XO_STWX:   ;
                XO_STWUX:  k.is_upd = 1'b1;
                XO_LHZX:   {k.is_load, k.is_half} = 2'b11;
                XO_LHZUX:  {k.is_load, k.is_half, k.is_upd} = 3'b111;
                XO_LHAX:   {k.is_load, k.is_half, k.is_alg} = 3'b111;
                XO_LHAUX:  {k.is_load, k.is_half, k.is_alg, k.is_upd} = 4'b1111;
                XO_STHX:   k.is_half = 1'b1;
                XO_STHUX:  {k.is_half, k.is_upd} = 2'b11;
                XO_LWBRX:  {k.is_load, k.is_rev} = 2'b11;
                XO_STWBRX: k.is_rev = 1'b1;
                XO_LHBRX:  {k.is_load, k.is_half, k.is_rev} = 3'b111;
                XO_STHBRX: {k.is_half, k.is_rev} = 2'b11;
                default:   k.known = 1'b0;
            endcase
        end
        else
        begin
            case (op)
                OP_LWZ:  k.is_load = 1'b1;
                OP_LWZU: {k.is_load, k.is_upd} = 2'b11;
                OP_STW:  ;
                OP_STWU: k.is_upd = 1'b1;
                OP_LHZ:  {k.is_load, k.is_half} = 2'b11;
                OP_LHZU: {k.is_load, k.is_half, k.is_upd} = 3'b111;
                OP_LHA:  {k.is_load, k.is_half, k.is_alg} = 3'b111;
                OP_LHAU: {k.is_load, k.is_half, k.is_alg, k.is_upd} = 4'b1111;
                OP_STH:  k.is_half = 1'b1;
                OP_STHU: {k.is_half, k.is_upd} = 2'b11;
                default: k.known = 1'b0;
            endcase
        end
        return k;
    endfunction

    // Work out the fixup that one trapped access must produce.
    function automatic fixup_t predict_fixup(input trap_t t);
        fixup_t       r;
        access_kind_t k;
        logic [4:0]   rs;
        logic [4:0]   ra;
        logic [15:0]  h;
        rs = t.instr_word[25:21];
        ra = t.instr_word[20:16];
        k  = classify_access(t.instr_word[31:26], t.instr_word[10:1]);
        r  = '0;
        r.report_address = t.fault_address;
        r.next_pc        = t.pc;
        r.target_index   = rs;
        r.base_index     = ra;
        if (t.fetch_fault)
        begin
            // Fetch fault wins: report the pc and clear both indexes.
            r.status         = ST_FETCH;
            r.report_address = t.pc;
            r.target_index   = '0;
            r.base_index     = '0;
        end
        else if (!k.known)
            r.status = ST_UNKNOWN;
        else if (t.access_fault)
            r.status = ST_DATA;
        else
        begin
            r.status  = ST_FIXED;
            r.next_pc = t.pc + PC_STEP;
            if (k.is_load)
            begin
                r.target_write = 1'b1;
                h = t.mem_data[15:0];
                if (!k.is_half)
                    r.target_value = k.is_rev
                        ? {t.mem_data[7:0], t.mem_data[15:8],
                           t.mem_data[23:16], t.mem_data[31:24]}
                        : t.mem_data;
                else if (k.is_rev)
                    // Byte reversed halfword is never sign extended.
                    r.target_value = {16'h0000, h[7:0], h[15:8]};
                else if (k.is_alg && h[15])
                    r.target_value = HALF_SIGN_FILL | {16'h0000, h};
                else
                    r.target_value = {16'h0000, h};
            end
            else
            begin
                r.store_enable  = 1'b1;
                r.store_is_half = k.is_half;
                h = t.source_value[15:0];
                if (k.is_half)
                    r.store_data = k.is_rev ? {16'h0000, h[7:0], h[15:8]}
                                            : {16'h0000, h};
                else
                    r.store_data = k.is_rev
                        ? {t.source_value[7:0], t.source_value[15:8],
                           t.source_value[23:16], t.source_value[31:24]}
                        : t.source_value;
            end
            // Invalid update form keeps the access but drops the RA write.
            if (k.is_upd)
            begin
                if (ra == 5'd0 || (k.is_load && ra == rs))
                    r.invalid_form = 1'b1;
                else
                    r.base_write = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Build the instruction word of one of the 24 emulated forms.
    function automatic logic [31:0] form_word(input int idx, input logic [4:0] rs,
                                              input logic [4:0] ra,
                                              input logic [15:0] low);
        logic [5:0] op;
        logic [9:0] xo;
        op = OP_X;
        xo = '0;
        case (idx)
            0:  op = OP_LWZ;
            1:  op = OP_LWZU;
            2:  op = OP_STW;
            3:  op = OP_STWU;
            4:  op = OP_LHZ;
            5:  op = OP_LHZU;
            6:  op = OP_LHA;
            7:  op = OP_LHAU;
            8:  op = OP_STH;
            9:  op = OP_STHU;
            10: xo = XO_LWZX;
            11: xo = XO_LWZUX;
            12: xo = XO_STWX;
            13: xo = XO_STWUX;
            14: xo = XO_LHZX;
            15: xo = XO_LHZUX;
            16: xo = XO_LHAX;
            17: xo = XO_LHAUX;
            18: xo = XO_STHX;
            19: xo = XO_STHUX;
            20: xo = XO_LWBRX;
            21: xo = XO_STWBRX;
            22: xo = XO_LHBRX;
            default: xo = XO_STHBRX;
        endcase
        // D forms carry a displacement in the low half; X forms carry rb and rc.
        if (op == OP_X)
            return {op, rs, ra, low[15:11], xo, low[0]};
        return {op, rs, ra, low};
    endfunction

    function automatic trap_t make_trap(input logic [31:0] word, input logic [31:0] at_pc,
                                        input logic [31:0] ea, input logic [31:0] src,
                                        input logic [31:0] mem, input logic ff,
                                        input logic af);
        trap_t t;
        t = '{word, at_pc, ea, src, mem, ff, af};
        return t;
    endfunction

    // Drive one item and hold it until the core takes it.
    task automatic send_item(input trap_t t);
        // Drop valid for random gaps before the item when gaps are on.
        while (gaps_enabled && $urandom_range(99) < 30)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        instr_word    <= t.instr_word;
        pc            <= t.pc;
        fault_address <= t.fault_address;
        source_value  <= t.source_value;
        mem_data      <= t.mem_data;
        fetch_fault   <= t.fetch_fault;
        access_fault  <= t.access_fault;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (fixups_pending.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    endtask

    task automatic check_fixup(input fixup_t got, input fixup_t want);
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.report_address != want.report_address)
            report_mismatch("report_address", got.report_address, want.report_address);
        if (got.next_pc != want.next_pc)
            report_mismatch("next_pc", got.next_pc, want.next_pc);
        if (got.store_enable != want.store_enable)
            report_mismatch("store_enable", 32'(got.store_enable), 32'(want.store_enable));
        if (got.store_is_half != want.store_is_half)
            report_mismatch("store_is_half", 32'(got.store_is_half),
                            32'(want.store_is_half));
        if (got.store_data != want.store_data)
            report_mismatch("store_data", got.store_data, want.store_data);
        if (got.target_write != want.target_write)
            report_mismatch("target_write", 32'(got.target_write), 32'(want.target_write));
        if (got.target_index != want.target_index)
            report_mismatch("target_index", 32'(got.target_index), 32'(want.target_index));
        if (got.target_value != want.target_value)
            report_mismatch("target_value", got.target_value, want.target_value);
        if (got.base_write != want.base_write)
            report_mismatch("base_write", 32'(got.base_write), 32'(want.base_write));
        if (got.base_index != want.base_index)
            report_mismatch("base_index", 32'(got.base_index), 32'(want.base_index));
        if (got.invalid_form != want.invalid_form)
            report_mismatch("invalid_form", 32'(got.invalid_form), 32'(want.invalid_form));
    endtask

    // Check each result taken, then queue the prediction for each item taken.
    // A result passes through both core registers after its item is taken, so the order is safe.
    always @(posedge clk)
    begin : result_monitor
        fixup_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{status_t'(status), report_address, next_pc, store_enable,
                        store_is_half, store_data, target_write, target_index,
                        target_value, base_write, base_index, invalid_form};
                if (fixups_pending.size() == 0)
                    report_mismatch("unexpected result, status", 32'(status), 32'd0);
                else
                    check_fixup(got, fixups_pending.pop_front());
            end
            if (in_valid && !in_stall)
                fixups_pending.push_back(predict_fixup(make_trap(instr_word, pc,
                    fault_address, source_value, mem_data, fetch_fault, access_fault)));
        end
    end

    // Stall the result side at random while gaps are on.
    always @(negedge clk)
        out_stall <= gaps_enabled && ($urandom_range(99) < 30);

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run every emulated form once with extreme data values.
    task automatic test_each_form();
        logic [4:0]  rs;
        logic [4:0]  ra;
        logic [31:0] mem;
        for (int idx = 0; idx < NUM_FORMS; idx++)
        begin
            rs = 5'($urandom_range(31, 1));
            ra = 5'((rs % 31) + 1);
            // Alternate the sign of the halfword so both extensions show up.
            mem = idx[0] ? 32'h0000_8000 : 32'hffff_7fff;
            if (idx % 3 == 2)
                mem = 32'hffff_ffff;
            send_item(make_trap(form_word(idx, rs, ra, 16'($urandom)),
                                idx[0] ? 32'hffff_fffc : 32'h0000_0000,
                                idx[1] ? 32'hffff_ffff : 32'h0000_0001,
                                idx[0] ? 32'hffff_ffff : 32'h1234_8001,
                                mem, 1'b0, 1'b0));
        end
    endtask

    // Faults, refused opcodes, invalid update forms and extension corners.
    task automatic test_special_cases();
        // Fetch fault on a good form, and on a refused opcode with a data fault too.
        send_item(make_trap(form_word(1, 5'd3, 5'd4, 16'h0002), 32'h0000_1000,
                            32'h0000_2001, 32'h1111_2222, 32'h3333_4444, 1'b1, 1'b0));
        send_item(make_trap({OP_LMW, 5'd31, 5'd31, 16'hffff}, 32'hffff_ffff,
                            32'h8000_0003, 32'h0, 32'h0, 1'b1, 1'b1));
        // Refused: lmw, stmw, opcode zero, opcode 31 with unlisted extended codes.
        send_item(make_trap({OP_LMW, 5'd5, 5'd6, 16'h0010}, 32'h0000_0400,
                            32'h0000_0011, 32'h0, 32'h0, 1'b0, 1'b0));
        send_item(make_trap({OP_STMW, 5'd7, 5'd8, 16'h0020}, 32'h0000_0404,
                            32'h0000_0021, 32'h0, 32'h0, 1'b0, 1'b0));
        send_item(make_trap(32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
        send_item(make_trap({OP_X, 5'd9, 5'd10, 5'd0, 10'd0, 1'b0}, 32'h0000_0800,
                            32'h0000_0033, 32'h0, 32'h0, 1'b0, 1'b0));
        send_item(make_trap({OP_X, 5'd9, 5'd10, 5'd31, 10'h3ff, 1'b1}, 32'h0000_0804,
                            32'h0000_0035, 32'h0, 32'h0, 1'b0, 1'b0));
        // Data fault on a store and on a load update form.
        send_item(make_trap(form_word(12, 5'd2, 5'd3, 16'h0), 32'h0000_0c00,
                            32'h0000_0041, 32'hdead_beef, 32'h0, 1'b0, 1'b1));
        send_item(make_trap(form_word(1, 5'd2, 5'd0, 16'h0), 32'h0000_0c04,
                            32'h0000_0043, 32'h0, 32'hcafe_f00d, 1'b0, 1'b1));
        // Update form with RA zero, load update with RA equal to RT.
        send_item(make_trap(form_word(3, 5'd4, 5'd0, 16'h0004), 32'h0000_1000,
                            32'h0000_0051, 32'h0102_0304, 32'h0, 1'b0, 1'b0));
        send_item(make_trap(form_word(11, 5'd6, 5'd6, 16'h0), 32'h0000_1004,
                            32'h0000_0053, 32'h0, 32'h0506_0708, 1'b0, 1'b0));
        // Store update with RA equal to RS is still a valid update.
        send_item(make_trap(form_word(19, 5'd7, 5'd7, 16'h0), 32'h0000_1008,
                            32'h0000_0055, 32'h0000_a1b2, 32'h0, 1'b0, 1'b0));
        // Byte reversed halfword whose swapped top bit is set stays zero extended.
        send_item(make_trap(form_word(22, 5'd8, 5'd9, 16'h0), 32'h0000_100c,
                            32'h0000_0057, 32'h0, 32'hffff_0080, 1'b0, 1'b0));
    endtask

    // Mostly good forms with random content, with refused opcodes and noise.
    task automatic test_random_traffic();
        int          pick;
        logic [4:0]  rs;
        logic [4:0]  ra;
        logic [5:0]  op;
        logic [31:0] word;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Run a long stretch with no gaps on either side.
            gaps_enabled = !(n >= 250 && n < 400);
            if (n == 500)
                wait_for_results();
            rs = 5'($urandom_range(31));
            case ($urandom_range(9))
                0:       ra = 5'd0;
                1, 2:    ra = rs;
                default: ra = 5'($urandom_range(31));
            endcase
            pick = $urandom_range(99);
            if (pick < 70)
                word = form_word($urandom_range(NUM_FORMS - 1), rs, ra, 16'($urandom));
            else if (pick < 85)
            begin
                case ($urandom_range(3))
                    0:       op = OP_LMW;
                    1:       op = OP_STMW;
                    2:       op = OP_X;
                    default: op = 6'($urandom_range(63));
                endcase
                word = {op, rs, ra, 16'($urandom)};
            end
            else
                word = $urandom;
            send_item(make_trap(word, $urandom, $urandom, $urandom, $urandom,
                                $urandom_range(99) < 8, $urandom_range(99) < 10));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        instr_word    = '0;
        pc            = '0;
        fault_address = '0;
        source_value  = '0;
        mem_data      = '0;
        fetch_fault   = 1'b0;
        access_fault  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_each_form();
        test_special_cases();
        test_random_traffic();

        // Drop valid, drain the pipeline and let it settle.
        @(negedge clk);
        in_valid <= 1'b0;
        while (fixups_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fixups_pending.size() != 0)
            report_mismatch("results never delivered", 32'(fixups_pending.size()), 32'd0);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
